[hdl/line_plane_intersection_defines.svh]
// ---------------------------------------------------------------------------
// line_plane_intersection_defines
// Assertion macros shared by the line/plane intersection RTL.
// ---------------------------------------------------------------------------
`ifndef LINE_PLANE_INTERSECTION_DEFINES_SVH
`define LINE_PLANE_INTERSECTION_DEFINES_SVH

// check a property on every clock edge outside reset
`define LPI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a condition implies a consequence in the same cycle
`define LPI_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[hdl/lpi_pkg.sv]
// ---------------------------------------------------------------------------
// lpi_pkg
// Types and constants for the line/plane intersection pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package lpi_pkg;

    localparam int DOT_W     = 67;
    localparam int DIV_STEPS = 32;
    localparam int DOT_LAT   = 5;
    localparam int HIT_LAT   = 3;
    localparam int LATENCY   = DOT_LAT + DIV_STEPS + HIT_LAT;
    localparam int NUM_REGS  = 8;

    localparam logic [31:0] NORMAL_Z_RESET = 32'h0001_0000;
    localparam logic [31:0] T_MAX          = 32'h7FFF_FFFF;
    localparam logic [31:0] T_MIN          = 32'h8000_0000;

    typedef enum logic [2:0] {
        REG_POINT_X  = 3'd0,
        REG_POINT_Y  = 3'd1,
        REG_POINT_Z  = 3'd2,
        REG_POINT_W  = 3'd3,
        REG_NORMAL_X = 3'd4,
        REG_NORMAL_Y = 3'd5,
        REG_NORMAL_Z = 3'd6,
        REG_NORMAL_W = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] start_w;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
        logic signed [31:0] end_w;
    } req_t;

    typedef struct packed {
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic signed [31:0] hit_z;
        logic signed [31:0] hit_w;
        logic signed [31:0] param_t;
        logic               parallel_flag;
    } rsp_t;

    typedef logic [3:0][31:0] vec4_t;

    typedef struct packed {
        logic [3:0][31:0] start;
        logic [3:0][32:0] diff;
        logic             neg;
        logic             par;
    } side_t;

    typedef struct packed {
        logic [DOT_W-1:0] rem;
        logic [DOT_W-1:0] den;
        logic [31:0]      nlo;
        logic [31:0]      quo;
        logic             ovf;
        side_t            side;
    } div_t;

endpackage

`default_nettype wire

[hdl/lpi_dot.sv]
// ---------------------------------------------------------------------------
// lpi_dot
// Dot products, numerator and denominator, magnitudes and divider setup.
// ---------------------------------------------------------------------------
`default_nettype none

module lpi_dot
    import lpi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire vec4_t a,
    input  wire vec4_t b,
    input  wire vec4_t p,
    input  wire vec4_t n,
    output logic       out_valid,
    output div_t       out_data
);

    logic [DOT_LAT-1:0] v_reg;

    logic signed [63:0] pa_reg [4];
    logic signed [63:0] pb_reg [4];
    logic signed [63:0] pp_reg [4];
    logic signed [63:0] pa_next [4];
    logic signed [63:0] pb_next [4];
    logic signed [63:0] pp_next [4];
    side_t sd1_reg, sd1_next;

    logic signed [65:0] sa_reg, sb_reg, sp_reg;
    logic signed [65:0] sa_next, sb_next, sp_next;
    side_t sd2_reg;

    logic signed [DOT_W-1:0] num_reg, den_reg, num_next, den_next;
    side_t sd3_reg;

    logic [DOT_W-1:0] nmag_reg, dmag_reg, nmag_next, dmag_next;
    side_t sd4_reg, sd4_next;

    div_t out_reg, out_next;

    always_comb
    begin
        sd1_next     = '0;
        for (int i = 0; i < 4; i++)
        begin
            pa_next[i] = 64'($signed(n[i])) * 64'($signed(a[i]));
            pb_next[i] = 64'($signed(n[i])) * 64'($signed(b[i]));
            pp_next[i] = 64'($signed(n[i])) * 64'($signed(p[i]));
            sd1_next.start[i] = a[i];
            sd1_next.diff[i]  = 33'(33'($signed(b[i])) - 33'($signed(a[i])));
        end
    end

    always_comb
    begin
        sa_next = 66'(pa_reg[0]) + 66'(pa_reg[1]) + 66'(pa_reg[2]) + 66'(pa_reg[3]);
        sb_next = 66'(pb_reg[0]) + 66'(pb_reg[1]) + 66'(pb_reg[2]) + 66'(pb_reg[3]);
        sp_next = 66'(pp_reg[0]) + 66'(pp_reg[1]) + 66'(pp_reg[2]) + 66'(pp_reg[3]);
        num_next = 67'(sp_reg) - 67'(sa_reg);
        den_next = 67'(sb_reg) - 67'(sa_reg);
    end

    always_comb
    begin
        nmag_next    = num_reg[DOT_W-1] ? DOT_W'(-num_reg) : DOT_W'(num_reg);
        dmag_next    = den_reg[DOT_W-1] ? DOT_W'(-den_reg) : DOT_W'(den_reg);
        sd4_next     = sd3_reg;
        sd4_next.neg = num_reg[DOT_W-1] ^ den_reg[DOT_W-1];
        sd4_next.par = (den_reg == '0);
    end

    always_comb
    begin
        out_next      = '0;
        out_next.rem  = DOT_W'(nmag_reg >> (32 - FRAC_BITS));
        out_next.den  = dmag_reg;
        out_next.nlo  = 32'({nmag_reg, {FRAC_BITS{1'b0}}});
        out_next.quo  = '0;
        out_next.ovf  = (DOT_W'(nmag_reg >> (32 - FRAC_BITS)) >= dmag_reg);
        out_next.side = sd4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[DOT_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        pp_reg   <= pp_next;
        sd1_reg  <= sd1_next;
        sa_reg   <= sa_next;
        sb_reg   <= sb_next;
        sp_reg   <= sp_next;
        sd2_reg  <= sd1_reg;
        num_reg  <= num_next;
        den_reg  <= den_next;
        sd3_reg  <= sd2_reg;
        nmag_reg <= nmag_next;
        dmag_reg <= dmag_next;
        sd4_reg  <= sd4_next;
        out_reg  <= out_next;
    end

    assign out_valid = v_reg[DOT_LAT-1];
    assign out_data  = out_reg;

endmodule

`default_nettype wire

[hdl/lpi_div.sv]
// ---------------------------------------------------------------------------
// lpi_div
// Pipelined restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module lpi_div
    import lpi_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire div_t in_data,
    output logic      out_valid,
    output div_t      out_data
);

    logic [DIV_STEPS-1:0] v_reg;
    div_t                 st_reg [DIV_STEPS];
    div_t                 st_next [DIV_STEPS];

    function automatic div_t div_step(div_t d);
        div_t         o;
        logic [DOT_W:0] sh;
        logic [DOT_W:0] trial;
        o     = d;
        sh    = {d.rem, d.nlo[31]};
        trial = sh - {1'b0, d.den};
        if (!trial[DOT_W])
        begin
            o.rem = trial[DOT_W-1:0];
            o.quo = {d.quo[30:0], 1'b1};
        end
        else
        begin
            o.rem = sh[DOT_W-1:0];
            o.quo = {d.quo[30:0], 1'b0};
        end
        o.nlo = {d.nlo[30:0], 1'b0};
        return o;
    endfunction

    always_comb
    begin
        st_next[0] = div_step(in_data);
        for (int k = 1; k < DIV_STEPS; k++)
        begin
            st_next[k] = div_step(st_reg[k-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[DIV_STEPS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
    end

    assign out_valid = v_reg[DIV_STEPS-1];
    assign out_data  = st_reg[DIV_STEPS-1];

endmodule

`default_nettype wire

[hdl/lpi_hit.sv]
// ---------------------------------------------------------------------------
// lpi_hit
// Saturate t, scale the segment direction and form the hit point.
// ---------------------------------------------------------------------------
`default_nettype none

module lpi_hit
    import lpi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire div_t in_data,
    output logic      out_valid,
    output rsp_t      out_data
);

    logic [HIT_LAT-1:0] v_reg;

    logic [31:0] t_reg, t_next;
    logic [31:0] tmag_reg, tmag_next;
    side_t       sd1_reg;

    logic [64:0] pr_reg [4];
    logic [64:0] pr_next [4];
    logic [3:0]  pneg_reg, pneg_next;
    logic [31:0] t2_reg;
    side_t       sd2_reg;

    rsp_t rsp_reg, rsp_next;

    always_comb
    begin
        priority if (in_data.side.par)
            t_next = '0;
        else if (in_data.ovf)
            t_next = in_data.side.neg ? T_MIN : T_MAX;
        else if (in_data.side.neg)
            t_next = (in_data.quo > T_MIN) ? T_MIN : 32'(-in_data.quo);
        else
            t_next = in_data.quo[31] ? T_MAX : in_data.quo;
        tmag_next = t_next[31] ? 32'(-t_next) : t_next;
    end

    always_comb
    begin
        logic [32:0] dmag;
        for (int i = 0; i < 4; i++)
        begin
            dmag         = sd1_reg.diff[i][32] ? 33'(-sd1_reg.diff[i]) : sd1_reg.diff[i];
            pr_next[i]   = 65'((65'(tmag_reg) * 65'(dmag)) >> FRAC_BITS);
            pneg_next[i] = t_reg[31] ^ sd1_reg.diff[i][32];
        end
    end

    function automatic logic [31:0] sat32(logic signed [66:0] s);
        logic [31:0] r;
        if (!s[66] && (|s[66:31]))
            r = T_MAX;
        else if (s[66] && !(&s[66:31]))
            r = T_MIN;
        else
            r = s[31:0];
        return r;
    endfunction

    always_comb
    begin
        logic signed [66:0] step;
        logic signed [66:0] sum;
        logic [3:0][31:0]   h;
        for (int i = 0; i < 4; i++)
        begin
            step = $signed({2'b00, pr_reg[i]});
            sum  = 67'($signed(sd2_reg.start[i])) + (pneg_reg[i] ? -step : step);
            h[i] = sd2_reg.par ? sd2_reg.start[i] : sat32(sum);
        end
        rsp_next.hit_x         = h[0];
        rsp_next.hit_y         = h[1];
        rsp_next.hit_z         = h[2];
        rsp_next.hit_w         = h[3];
        rsp_next.param_t       = t2_reg;
        rsp_next.parallel_flag = sd2_reg.par;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[HIT_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        tmag_reg <= tmag_next;
        sd1_reg  <= in_data.side;
        pr_reg   <= pr_next;
        pneg_reg <= pneg_next;
        t2_reg   <= t_reg;
        sd2_reg  <= sd1_reg;
        rsp_reg  <= rsp_next;
    end

    assign out_valid = v_reg[HIT_LAT-1];
    assign out_data  = rsp_reg;

endmodule

`default_nettype wire

[hdl/line_plane_intersection.sv]
// Throughput: one request per cycle; busy stays low.
// The 32-stage restoring divider sets most of the latency.
// Reset clears all valid bits and loads the plane registers to their defaults.
// Results appear for one cycle on done; the receiver cannot stall.
// ---------------------------------------------------------------------------
// line_plane_intersection
// Segment against plane clip: t and hit point in signed fixed point.
// ---------------------------------------------------------------------------
`default_nettype none

`include "line_plane_intersection_defines.svh"

module line_plane_intersection
    import lpi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        start,
    output logic             busy,
    input  wire req_t        req,
    output logic             done,
    output rsp_t             rsp
);

    logic [31:0] cfg_reg [NUM_REGS];
    logic [2:0]  widx;

    vec4_t a, b, p, n;
    logic  dot_valid, div_valid;
    div_t  dot_data, div_data;

    assign widx   = paddr[4:2];
    assign pready = 1'b1;
    assign prdata = cfg_reg[widx];
    assign busy   = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= (i == int'(REG_NORMAL_Z)) ? NORMAL_Z_RESET : '0;
            end
        end
        else if (psel && penable && pwrite && pready)
        begin
            cfg_reg[widx] <= pwdata;
        end
    end

    always_comb
    begin
        a = {req.start_w, req.start_z, req.start_y, req.start_x};
        b = {req.end_w, req.end_z, req.end_y, req.end_x};
        p = {cfg_reg[REG_POINT_W], cfg_reg[REG_POINT_Z],
             cfg_reg[REG_POINT_Y], cfg_reg[REG_POINT_X]};
        n = {cfg_reg[REG_NORMAL_W], cfg_reg[REG_NORMAL_Z],
             cfg_reg[REG_NORMAL_Y], cfg_reg[REG_NORMAL_X]};
    end

    lpi_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .a         (a),
        .b         (b),
        .p         (p),
        .n         (n),
        .out_valid (dot_valid),
        .out_data  (dot_data)
    );

    lpi_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dot_valid),
        .in_data   (dot_data),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    lpi_hit #(.FRAC_BITS(FRAC_BITS)) u_hit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_data   (div_data),
        .out_valid (done),
        .out_data  (rsp)
    );

    `LPI_ASSERT_IMPLY(a_done_source, done, $past(start && !busy, LATENCY), "done without request")
    `LPI_ASSERT_IMPLY(a_par_hit, done && rsp.parallel_flag, (rsp.hit_x == $past(req.start_x, LATENCY)) && (rsp.hit_w == $past(req.start_w, LATENCY)), "parallel hit not start")
    `LPI_ASSERT(a_par_t, !(done && rsp.parallel_flag) || (rsp.param_t == '0), "parallel t nonzero")

endmodule

`default_nettype wire
